@@ rtl/core/u2d_pkg.sv @@
// Shared types and byte-class constants for the UTF-8 to UCS-2 decoder.
`default_nettype none

package u2d_pkg;

  // Byte classification masks and patterns
  localparam logic [7:0] TOP_MASK    = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'he0;
  localparam logic [7:0] LEAD2_PAT   = 8'hc0;
  localparam logic [7:0] LEAD3_MASK  = 8'hf0;
  localparam logic [7:0] LEAD3_PAT   = 8'he0;
  localparam logic [7:0] CONT_MASK   = 8'hc0;
  localparam logic [7:0] CONT_PAT    = 8'h80;
  localparam logic [7:0] LEAD2_DATA  = 8'h1f;
  localparam logic [7:0] LEAD3_DATA  = 8'h0f;
  localparam logic [7:0] CONT_DATA   = 8'h3f;
  localparam logic [7:0] TAB_CHAR    = 8'd9;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;

  // Payload bytes still owed to a multi-byte character
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic        emit;
    logic [15:0] code_point;
  } result_t;

  typedef struct packed {
    logic [1:0] bytes_pending;
    logic       skipping;
  } dec_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/utf8_to_ucs2_decoder.sv @@
// Path: a byte passes the input register, then the result register, before out_valid rises.
// Throughput: one byte per unstalled cycle; decode of each byte is one pass of logic against state.
// A byte that completes no character takes its cycle and leaves no result.
// Reset: synchronous, active-low rst_n clears both valid flags and all decoder state.
// in_stall rises only while a request is held and the result register is stalled.
`default_nettype none

module utf8_to_ucs2_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_code_point
);

  logic                s1_valid_r;
  u2d_pkg::item_t      s1_item_r;
  logic                s1_adv;
  logic                out_open;
  logic                out_valid_r;
  logic [15:0]         out_code_point_r;
  u2d_pkg::result_t    dec_res;
  u2d_pkg::dec_stat_t  dec_stat;

  assign out_open = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_open;
  assign in_stall = s1_valid_r && !out_open;

  // Input register: load when the held request moves on or is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item_r.text_byte   <= in_text_byte;
      s1_item_r.end_of_text <= in_end_of_text;
    end
  end

  u2d_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_adv),
    .item  (s1_item_r),
    .res   (dec_res),
    .stat  (dec_stat)
  );

  // Result register: refill whenever the downstream side takes or is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_open) begin
      out_valid_r <= s1_valid_r && dec_res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && s1_valid_r && dec_res.emit) begin
      out_code_point_r <= dec_res.code_point;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_code_point_r;

`ifndef SYNTHESIS
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    dec_stat.bytes_pending != 2'd3)
    else $error("bytes_pending holds an impossible count");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_item_r.end_of_text) |=>
      (dec_stat.bytes_pending == u2d_pkg::PEND_NONE && !dec_stat.skipping))
    else $error("end of text did not clear decoder state");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && s1_valid_r))
    else $error("input stalled without a stalled result");

  a_skip_pend: assert property (@(posedge clk) disable iff (!rst_n)
    dec_stat.skipping |-> (dec_stat.bytes_pending == u2d_pkg::PEND_NONE))
    else $error("skipping while a character is pending");
`endif

endmodule

`default_nettype wire

@@ rtl/core/u2d_decode.sv @@
// Decoder state and combinational byte decode logic.
`default_nettype none

module u2d_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire u2d_pkg::item_t    item,
  output u2d_pkg::result_t       res,
  output u2d_pkg::dec_stat_t     stat
);

  logic [1:0]  bytes_pending_r, bytes_pending_nxt;
  logic [15:0] partial_value_r, partial_value_nxt;
  logic        skipping_r, skipping_nxt;
  logic [7:0]  b;

  assign b = item.text_byte;

  // Decode one byte against the current state
  always_comb begin
    bytes_pending_nxt = bytes_pending_r;
    partial_value_nxt = partial_value_r;
    skipping_nxt      = skipping_r;
    res.emit          = 1'b0;
    res.code_point    = partial_value_r;

    if (bytes_pending_r != u2d_pkg::PEND_NONE) begin
      partial_value_nxt = {partial_value_r[9:0], b[5:0]};
      bytes_pending_nxt = bytes_pending_r - 2'd1;
      res.emit          = (bytes_pending_r == u2d_pkg::PEND_ONE);
      res.code_point    = {partial_value_r[9:0], b[5:0]};
    end else if (skipping_r && ((b & u2d_pkg::CONT_MASK) == u2d_pkg::CONT_PAT)) begin
      // drop continuation of an unsupported sequence
    end else begin
      skipping_nxt = 1'b0;
      if ((b & u2d_pkg::TOP_MASK) == 8'h00) begin
        res.emit       = 1'b1;
        res.code_point = {8'h00, (b == u2d_pkg::TAB_CHAR) ? u2d_pkg::SPACE_CHAR : b};
      end else if ((b & u2d_pkg::LEAD2_MASK) == u2d_pkg::LEAD2_PAT) begin
        partial_value_nxt = {8'h00, b & u2d_pkg::LEAD2_DATA};
        bytes_pending_nxt = u2d_pkg::PEND_ONE;
      end else if ((b & u2d_pkg::LEAD3_MASK) == u2d_pkg::LEAD3_PAT) begin
        partial_value_nxt = {8'h00, b & u2d_pkg::LEAD3_DATA};
        bytes_pending_nxt = u2d_pkg::PEND_TWO;
      end else begin
        skipping_nxt = 1'b1;
      end
    end

    // Clear all state after the last byte of the text
    if (item.end_of_text) begin
      bytes_pending_nxt = u2d_pkg::PEND_NONE;
      partial_value_nxt = 16'h0000;
      skipping_nxt      = 1'b0;
    end
  end

  // Advance state when the request moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_pending_r <= u2d_pkg::PEND_NONE;
      partial_value_r <= 16'h0000;
      skipping_r      <= 1'b0;
    end else if (adv) begin
      bytes_pending_r <= bytes_pending_nxt;
      partial_value_r <= partial_value_nxt;
      skipping_r      <= skipping_nxt;
    end
  end

  assign stat.bytes_pending = bytes_pending_r;
  assign stat.skipping      = skipping_r;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for the UTF-8 to UCS-2 decoder: byte driver, code point checker and decode predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int SEQS_PER_PHASE = 140;
  localparam int NUM_PHASES     = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte = '0;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_code_point;

  // Bytes waiting to be driven and code points waiting to come out
  u2d_pkg::item_t pending_bytes[$];
  logic [15:0]    expected_code_points[$];

  // Decoder state as the predictor sees it
  logic [1:0]  owed_bytes = u2d_pkg::PEND_NONE;
  logic [15:0] gathered_bits = '0;
  logic        skipping_cont = 1'b0;

  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  logic           hold_request = 1'b0;
  logic           hold_started = 1'b0;
  int             hold_left = 0;
  int             mismatch_count = 0;
  int             quiet_cycles = 0;
  u2d_pkg::item_t next_req;

  utf8_to_ucs2_decoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_end_of_text(in_end_of_text),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_point(out_code_point)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Advance the predicted decoder state by one byte; queue any completed character
  task automatic decode_byte(input logic [7:0] b, input logic last);
    if (owed_bytes != u2d_pkg::PEND_NONE) begin
      gathered_bits = {gathered_bits[9:0], b[5:0] & u2d_pkg::CONT_DATA[5:0]};
      owed_bytes = owed_bytes - 2'd1;
      if (owed_bytes == u2d_pkg::PEND_NONE)
        expected_code_points.push_back(gathered_bits);
    end else if (skipping_cont && (b & u2d_pkg::CONT_MASK) == u2d_pkg::CONT_PAT) begin
      // drop continuation of an unsupported sequence
    end else begin
      skipping_cont = 1'b0;
      if ((b & u2d_pkg::TOP_MASK) == 8'h00) begin
        expected_code_points.push_back((b == u2d_pkg::TAB_CHAR) ?
                                       {8'h00, u2d_pkg::SPACE_CHAR} : {8'h00, b});
      end else if ((b & u2d_pkg::LEAD2_MASK) == u2d_pkg::LEAD2_PAT) begin
        gathered_bits = {8'h00, b & u2d_pkg::LEAD2_DATA};
        owed_bytes = u2d_pkg::PEND_ONE;
      end else if ((b & u2d_pkg::LEAD3_MASK) == u2d_pkg::LEAD3_PAT) begin
        gathered_bits = {8'h00, b & u2d_pkg::LEAD3_DATA};
        owed_bytes = u2d_pkg::PEND_TWO;
      end else begin
        skipping_cont = 1'b1;
      end
    end
    if (last) begin
      owed_bytes = u2d_pkg::PEND_NONE;
      gathered_bits = '0;
      skipping_cont = 1'b0;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    u2d_pkg::item_t req;
    req.text_byte = b;
    req.end_of_text = last;
    pending_bytes.push_back(req);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // Payload byte: mostly a proper continuation, sometimes any byte at all
  function automatic logic [7:0] payload_byte();
    if ($urandom_range(7) == 0)
      return 8'($urandom_range(255));
    return cont_byte();
  endfunction

  // Queue one random character or fragment, mostly well formed
  task automatic queue_random_seq();
    int   kind;
    int   n;
    logic mark;
    kind = $urandom_range(99);
    mark = ($urandom_range(19) == 0);
    if (kind < 30) begin
      queue_byte(($urandom_range(9) == 0) ? u2d_pkg::TAB_CHAR : 8'($urandom_range(127)), mark);
    end else if (kind < 50) begin
      queue_byte(u2d_pkg::LEAD2_PAT | 8'($urandom_range(31)), 1'b0);
      queue_byte(payload_byte(), mark);
    end else if (kind < 70) begin
      queue_byte(u2d_pkg::LEAD3_PAT | 8'($urandom_range(15)), 1'b0);
      queue_byte(payload_byte(), 1'b0);
      queue_byte(payload_byte(), mark);
    end else if (kind < 80) begin
      // unsupported lead: stray continuation or long lead, then its tail
      n = $urandom_range(3);
      if ($urandom_range(1) == 0)
        queue_byte(cont_byte(), mark && n == 0);
      else
        queue_byte(8'hf0 | 8'($urandom_range(15)), mark && n == 0);
      for (int i = 0; i < n; i++)
        queue_byte(cont_byte(), mark && i == n - 1);
    end else if (kind < 90) begin
      queue_byte(8'($urandom_range(255)), mark);
    end else begin
      // truncated character closed by the end marker
      if ($urandom_range(1) == 0) begin
        queue_byte(u2d_pkg::LEAD2_PAT | 8'($urandom_range(31)), 1'b1);
      end else begin
        n = $urandom_range(1);
        queue_byte(u2d_pkg::LEAD3_PAT | 8'($urandom_range(15)), n == 0);
        if (n == 1)
          queue_byte(payload_byte(), 1'b1);
      end
    end
  endtask

  // Driver: predict on accept, then offer the next request or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        decode_byte(in_text_byte, in_end_of_text);
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_text_byte <= next_req.text_byte;
          in_end_of_text <= next_req.end_of_text;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each code point against the oldest prediction, drive stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_code_points.size() == 0) begin
        report_mismatch($sformatf("code point %h with nothing expected", out_code_point));
      end else if (out_code_point !== expected_code_points[0]) begin
        report_mismatch($sformatf("code point %h, expected %h",
                                  out_code_point, expected_code_points[0]));
        void'(expected_code_points.pop_front());
      end else begin
        void'(expected_code_points.pop_front());
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_request && !hold_started) begin
      hold_started <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int send_pct[NUM_PHASES];
    int recv_pct[NUM_PHASES];
    send_pct = '{0, 53, 0, 26};
    recv_pct = '{0, 0, 53, 26};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: ASCII extremes and tab
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7f, 1'b0);
    queue_byte(u2d_pkg::TAB_CHAR, 1'b0);
    // two-byte extremes
    queue_byte(8'hc0, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hdf, 1'b0);
    queue_byte(8'hbf, 1'b0);
    // three-byte maximum
    queue_byte(8'hef, 1'b0);
    queue_byte(8'hbf, 1'b0);
    queue_byte(8'hbf, 1'b0);
    // non-continuation payload byte taken anyway
    queue_byte(8'he2, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'hff, 1'b0);
    // stray continuation, its tail, then end of skipping on an ASCII byte
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hbf, 1'b0);
    queue_byte(8'h41, 1'b0);
    // long lead dropped, skipping ended by a two-byte lead completed by marked byte
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h9f, 1'b0);
    queue_byte(8'hc2, 1'b0);
    queue_byte(8'ha9, 1'b1);
    // truncated three-byte character at end of text
    queue_byte(8'he2, 1'b0);
    queue_byte(8'h82, 1'b1);
    // marker while skipping clears it, so the next continuation is a stray lead
    queue_byte(8'hf8, 1'b1);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h09, 1'b1);
    while (pending_bytes.size() != 0) @(negedge clk);

    // Random phases with varying idle and stall rates
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      for (int s = 0; s < SEQS_PER_PHASE; s++)
        queue_random_seq();
      // long receiver hold-off while the sender keeps offering
      if (p == 0)
        hold_request = 1'b1;
      while (pending_bytes.size() != 0) @(negedge clk);
    end

    // Drain remaining results
    while (in_valid || expected_code_points.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_code_points.size() != 0)
      report_mismatch("code points still expected at end");

    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
